[design/plstc_pkg.sv]
package plstc_pkg;

   localparam int LINKS  = 16;
   localparam int LINK_W = $clog2(LINKS);
   localparam int AVG_W  = 18;
   localparam int IDLE_W = 16;
   localparam int TGT_W  = 9;
   localparam int ERR_W  = 20;

   localparam logic [IDLE_W-1:0]       IDLE_MAX   = 16'hFFFE;
   // dead band edge: -2.0 in Q.8
   localparam logic signed [ERR_W-1:0] HYST_LIMIT = -20'sd512;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_FRESH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HYSTERESIS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FUTURE_LEN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SF_PER_MSF  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GTS_FIRST   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GTS_OTHER   = 3'd6;

   typedef enum logic [1:0] {
      ACT_NONE    = 2'd0,
      ACT_ALLOC   = 2'd1,
      ACT_DEALLOC = 2'd2
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_NEW,
      ST_MUL_OLD,
      ST_UPDATE,
      ST_CHECK,
      ST_OFFSET,
      ST_SUPERFRAME,
      ST_SLOT,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      DIV_OFFSET,
      DIV_SUPERFRAME,
      DIV_SLOT
   } div_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_new;
      logic        mul_old;
      logic        tick_write;
      logic        set_action;
      logic        div_start;
      div_sel_type div_sel;
      logic        take_sf;
      logic        take_slot;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      logic req_op;
      logic need_alloc;
      logic div_done;
      logic out_free;
   } stat_type;

endpackage

[design/plstc_div.sv]
module plstc_div (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [15:0] dividend,
   input  logic [7:0] divisor,
   output logic       busy,
   output logic       done,
   output logic [7:0] rem
);
   logic [15:0] dvd_ff;
   logic [7:0]  dvsr_ff;
   logic [7:0]  rem_ff;
   logic [3:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [8:0]  trial;
   logic [8:0]  diff;

   // restoring remainder, one dividend bit per cycle
   assign trial = {rem_ff, dvd_ff[15]};
   assign diff  = trial - {1'b0, dvsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff  <= dividend;
         dvsr_ff <= divisor;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[14:0], 1'b0};
         if (trial >= {1'b0, dvsr_ff}) begin
            rem_ff <= diff[7:0];
         end else begin
            rem_ff <= trial[7:0];
         end
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

[design/plstc_ctrl.sv]
module plstc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  plstc_pkg::stat_type stat,
   output plstc_pkg::cmd_type  cmd
);
   import plstc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = stat.req_op ? ST_CHECK : ST_MUL_NEW;
            end
         end
         ST_MUL_NEW: begin
            cmd.mul_new = 1'b1;
            state_in    = ST_MUL_OLD;
         end
         ST_MUL_OLD: begin
            cmd.mul_old = 1'b1;
            state_in    = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.tick_write = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_CHECK: begin
            cmd.set_action = 1'b1;
            if (stat.need_alloc) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_OFFSET;
               state_in      = ST_OFFSET;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_OFFSET: begin
            if (stat.div_done) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_SUPERFRAME;
               state_in      = ST_SUPERFRAME;
            end
         end
         ST_SUPERFRAME: begin
            if (stat.div_done) begin
               cmd.take_sf   = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_SLOT;
               state_in      = ST_SLOT;
            end
         end
         ST_SLOT: begin
            if (stat.div_done) begin
               cmd.take_slot = 1'b1;
               state_in      = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[design/plstc_dp.sv]
module plstc_dp (
   input  logic                clock,
   input  logic                reset,
   input  logic [63:0]         req_tdata,
   input  logic                req_tuser,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_wdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,
   output logic [1:0]          rsp_tuser,
   input  plstc_pkg::cmd_type  cmd,
   output plstc_pkg::stat_type stat
);
   import plstc_pkg::*;

   // configuration
   logic [8:0]  alpha_ff;
   logic [15:0] min_fresh_ff;
   logic        hyst_ff;
   logic [7:0]  future_len_ff;
   logic [7:0]  sf_per_msf_ff;
   logic [3:0]  gts_first_ff;
   logic [3:0]  gts_other_ff;

   // link table
   logic [AVG_W-1:0]  avg_ff  [LINKS];
   logic [IDLE_W-1:0] idle_ff [LINKS];
   logic [TGT_W-1:0]  tgt_ff  [LINKS];

   // captured item
   logic [LINK_W-1:0] link_ff;
   logic [9:0]        msgs_ff;
   logic [7:0]        slots_ff;
   logic [7:0]        cur_ff;
   logic [15:0]       rand_a_ff;
   logic [15:0]       rand_b_ff;

   logic [17:0]       prod_new_ff;
   logic [25:0]       prod_old_ff;

   logic [TGT_W-1:0]  res_target_ff;
   action_type        res_action_ff;
   logic [7:0]        sf_ff;
   logic [3:0]        slot_ff;

   logic              rsp_valid_ff;
   logic [23:0]       rsp_data_ff;
   logic [1:0]        rsp_user_ff;

   logic [AVG_W-1:0]  avg_rd;
   logic [IDLE_W-1:0] idle_rd;
   logic [TGT_W-1:0]  tgt_rd;

   logic [8:0]              a_eff;
   logic [8:0]              a_inv;
   logic [18:0]             mul_new_w;
   logic [26:0]             mul_old_w;
   logic [18:0]             avg_sum;
   logic [AVG_W-1:0]        avg_in;
   logic signed [ERR_W-1:0] err;
   logic signed [ERR_W-1:0] err_up;
   logic signed [11:0]      ceil_w;
   logic signed [11:0]      chg;
   logic signed [7:0]       chg_sat;
   logic signed [9:0]       tgt_sum;
   logic [TGT_W-1:0]        tgt_clamp;
   logic                    stale;
   logic [TGT_W-1:0]        tgt_in;
   logic [IDLE_W-1:0]       idle_in;
   logic                    dealloc;

   logic [7:0]  off_w;
   logic [8:0]  sf_sum;
   logic [7:0]  sf_now;
   logic [3:0]  gts_now;
   logic [3:0]  gts_held;
   logic [15:0] div_dividend;
   logic [7:0]  div_divisor;
   logic        div_busy;
   logic        div_done;
   logic [7:0]  div_rem;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff      <= 9'd26;
         min_fresh_ff  <= 16'd8;
         hyst_ff       <= 1'b1;
         future_len_ff <= 8'd1;
         sf_per_msf_ff <= 8'd4;
         gts_first_ff  <= 4'd7;
         gts_other_ff  <= 4'd15;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ALPHA:      alpha_ff      <= csr_wdata[8:0];
            CSR_MIN_FRESH:  min_fresh_ff  <= csr_wdata;
            CSR_HYSTERESIS: hyst_ff       <= csr_wdata[0];
            CSR_FUTURE_LEN: future_len_ff <= csr_wdata[7:0];
            CSR_SF_PER_MSF: sf_per_msf_ff <= csr_wdata[7:0];
            CSR_GTS_FIRST:  gts_first_ff  <= csr_wdata[3:0];
            CSR_GTS_OTHER:  gts_other_ff  <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         link_ff   <= req_tdata[3:0];
         msgs_ff   <= req_tdata[13:4];
         slots_ff  <= req_tdata[21:14];
         cur_ff    <= req_tdata[29:22];
         rand_a_ff <= req_tdata[45:30];
         rand_b_ff <= req_tdata[61:46];
      end
   end

   assign avg_rd  = avg_ff[link_ff];
   assign idle_rd = idle_ff[link_ff];
   assign tgt_rd  = tgt_ff[link_ff];

   // moving average: p_new = msgs*a, p_old = avg*(256-a), avg' = p_new + p_old/256
   assign a_eff     = (alpha_ff > 9'd256) ? 9'd256 : alpha_ff;
   assign a_inv     = 9'd256 - a_eff;
   assign mul_new_w = msgs_ff * a_eff;
   assign mul_old_w = avg_rd * a_inv;

   always_ff @(posedge clock) begin
      if (cmd.mul_new) begin
         prod_new_ff <= mul_new_w[17:0];
      end
      if (cmd.mul_old) begin
         prod_old_ff <= mul_old_w[25:0];
      end
   end

   assign avg_sum = {1'b0, prod_new_ff} + {1'b0, prod_old_ff[25:8]};
   assign avg_in  = avg_sum[AVG_W-1:0];

   // error in Q.8 and its ceiling
   assign err    = signed'({2'b00, avg_in}) - signed'({4'b0000, slots_ff, 8'h00});
   assign err_up = err + 20'sd255;
   assign ceil_w = err_up[19:8];

   always_comb begin
      if (!hyst_ff || err > 20'sd0) begin
         chg = ceil_w;
      end else if (err < HYST_LIMIT) begin
         chg = ceil_w + 12'sd1;
      end else begin
         chg = '0;
      end
      if (chg > 12'sd127) begin
         chg_sat = 8'sd127;
      end else if (chg < -12'sd128) begin
         chg_sat = -8'sd128;
      end else begin
         chg_sat = chg[7:0];
      end
   end

   assign tgt_sum   = signed'({2'b00, slots_ff}) + signed'({{2{chg_sat[7]}}, chg_sat});
   assign tgt_clamp = tgt_sum[9] ? '0 : tgt_sum[8:0];
   assign stale     = idle_rd > min_fresh_ff;
   assign tgt_in    = stale ? '0 : tgt_clamp;

   always_comb begin
      if (msgs_ff != '0) begin
         idle_in = '0;
      end else if (idle_rd < IDLE_MAX) begin
         idle_in = idle_rd + 16'd1;
      end else begin
         idle_in = idle_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINKS; i++) begin
            avg_ff[i]  <= '0;
            idle_ff[i] <= '0;
            tgt_ff[i]  <= '0;
         end
      end else if (cmd.tick_write) begin
         avg_ff[link_ff]  <= avg_in;
         idle_ff[link_ff] <= idle_in;
         tgt_ff[link_ff]  <= tgt_in;
      end
   end

   // query decision
   assign stat.need_alloc = tgt_rd > {1'b0, slots_ff};
   assign dealloc         = (tgt_rd < {1'b0, slots_ff}) && (slots_ff > 8'd1);

   // operands for the shared remainder unit
   assign off_w    = (future_len_ff == '0) ? '0 : div_rem;
   assign sf_sum   = {1'b0, cur_ff} + {1'b0, off_w};
   assign sf_now   = (sf_per_msf_ff == '0) ? '0 : div_rem;
   assign gts_now  = (sf_now == '0) ? gts_first_ff : gts_other_ff;
   assign gts_held = (sf_ff == '0) ? gts_first_ff : gts_other_ff;

   always_comb begin
      case (cmd.div_sel)
         DIV_OFFSET: begin
            div_dividend = rand_a_ff;
            div_divisor  = future_len_ff;
         end
         DIV_SUPERFRAME: begin
            div_dividend = {7'd0, sf_sum};
            div_divisor  = sf_per_msf_ff;
         end
         DIV_SLOT: begin
            div_dividend = rand_b_ff;
            div_divisor  = {4'd0, gts_now};
         end
         default: begin
            div_dividend = rand_a_ff;
            div_divisor  = future_len_ff;
         end
      endcase
   end

   plstc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .rem      (div_rem)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_action_ff <= ACT_NONE;
         sf_ff         <= '0;
         slot_ff       <= '0;
      end
      if (cmd.tick_write) begin
         res_target_ff <= tgt_in;
      end
      if (cmd.set_action) begin
         res_target_ff <= tgt_rd;
         if (stat.need_alloc) begin
            res_action_ff <= ACT_ALLOC;
         end else if (dealloc) begin
            res_action_ff <= ACT_DEALLOC;
         end else begin
            res_action_ff <= ACT_NONE;
         end
      end
      if (cmd.take_sf) begin
         sf_ff <= sf_now;
      end
      if (cmd.take_slot) begin
         slot_ff <= (gts_held == '0) ? '0 : div_rem[3:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= {3'b000, slot_ff, sf_ff, res_target_ff};
         rsp_user_ff <= res_action_ff;
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = rsp_data_ff;
   assign rsp_tuser     = rsp_user_ff;
   assign stat.req_op   = req_tuser;
   assign stat.div_done = div_done;
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result emitted over a waiting item");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy)
      else $error("remainder unit restarted while busy");

   a_stale_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.tick_write && stale) |=> (res_target_ff == '0))
      else $error("stale link kept a nonzero target");

endmodule

[design/per_link_slot_target_controller.sv]
// channel  | direction | handshake             | payload
// req_     | in        | req_tvalid/req_tready | tuser: op; tdata: link, messages, slots, ...
// rsp_     | out       | rsp_tvalid/rsp_tready | tuser: action; tdata: target, sf, slot
// csr_     | in        | csr_we                | csr_index, csr_wdata
//
// One item at a time. A tick goes through two multiply steps and one table update.
// A query that allocates sends three remainders through one shared bit-serial unit.
// Synchronous reset clears the link table and loads the register defaults.
// A waiting result sits in the output register; the next item is taken meanwhile.
module per_link_slot_target_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // link, messages_in, allocated_slots,
                                   // current_superframe, random_a, random_b, pad
   input  logic        req_tuser,  // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // slot_target, superframe_id, slot_id, pad
   output logic [1:0]  rsp_tuser,  // action
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import plstc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   plstc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   plstc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule
